/* rtl/core/baro_pkg.sv */
`default_nettype none
package baro_pkg;

  // Calibration words unpacked from the four configuration registers.
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } cal_t;

  // One raw reading pair as it moves from the queue to the engine.
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;
  } item_t;

  // Configuration register indexes.
  localparam logic [1:0] CfgOffset = 2'd0;
  localparam logic [1:0] CfgScale  = 2'd1;
  localparam logic [1:0] CfgB      = 2'd2;
  localparam logic [1:0] CfgM      = 2'd3;

  // Compensation constants.
  localparam logic [63:0] TempOffset   = 64'd4000;
  localparam logic [63:0] PressBias    = 64'd32768;
  localparam logic [63:0] PressScale   = 64'd50000;
  localparam logic [63:0] SmallLimit   = 64'h0000_0000_8000_0000;
  localparam logic [63:0] CoefSquare   = 64'd3038;
  localparam logic [63:0] CoefLinear   = 64'hFFFF_FFFF_FFFF_E343; // -7357
  localparam logic [63:0] CoefOffset   = 64'd3791;

  // Sign extension of a 16-bit calibration word to 64 bits.
  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed division by 2^k that truncates toward zero.
  function automatic logic [63:0] sdiv_p2(input logic [63:0] x, input int unsigned k);
    logic [63:0] bias;
    bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
    return 64'($signed(x + bias) >>> k);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/baro_if.sv */
`default_nettype none
// Raw reading channel.
interface baro_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [15:0] raw_pressure;
  modport source(output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink(input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

// Compensated result channel.
interface baro_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_decideg;
  logic signed [31:0] pressure_pa;
  logic               divide_error;
  modport source(output valid, output temperature_decideg, output pressure_pa,
                 output divide_error, input ready);
  modport sink(input valid, input temperature_decideg, input pressure_pa,
               input divide_error, output ready);
endinterface
`default_nettype wire

/* rtl/core/barometer_compensation_core.sv */
`default_nettype none
// Pressure and temperature compensation core.
// Raw readings enter on in_if (raw_temperature, raw_pressure); each transfer
// yields exactly one transfer on out_if carrying the temperature in 0.1 degC,
// the pressure in Pa, both saturated, and divide_error, which is set with zero
// results when a divisor is zero.
// The four calibration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the core is idle, and the
// core does not enforce this. They reset to zero. A queue of QueueDepth
// entries takes readings while the engine works. The engine runs one reading
// at a time through a shared 32x32 multiplier and a radix-2 64-bit divider;
// a reading without a divide error takes eleven products and two divides.
// Reset empties the queue and drops any result in flight.
// While the receiver stalls, the finished result holds in the output
// register, the engine waits with the next one, and the queue keeps filling.
module barometer_compensation_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  baro_in_if.sink          in_if,
  baro_out_if.source       out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);

  logic [47:0]     cal_offset_q, cal_scale_q;
  logic [31:0]     cal_b_q, cal_m_q;
  baro_pkg::cal_t  cal;
  baro_pkg::item_t item;
  logic            item_valid, item_ready;

  // Calibration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_offset_q <= '0;
      cal_scale_q  <= '0;
      cal_b_q      <= '0;
      cal_m_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        baro_pkg::CfgOffset: cal_offset_q <= cfg_data_i;
        baro_pkg::CfgScale:  cal_scale_q  <= cfg_data_i;
        baro_pkg::CfgB:      cal_b_q      <= cfg_data_i[31:0];
        baro_pkg::CfgM:      cal_m_q      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cal = '{ac1: cal_offset_q[47:32], ac2: cal_offset_q[31:16], ac3: cal_offset_q[15:0],
                 ac4: cal_scale_q[47:32],  ac5: cal_scale_q[31:16],  ac6: cal_scale_q[15:0],
                 b1: cal_b_q[31:16], b2: cal_b_q[15:0],
                 mc: cal_m_q[31:16], md: cal_m_q[15:0]};

  baro_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  baro_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_ready_o (item_ready),
    .cal_i        (cal),
    .out_if       (out_if)
  );

endmodule
`default_nettype wire

/* rtl/core/baro_front.sv */
`default_nettype none
module baro_front #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  baro_in_if.sink             in_if,
  output logic                item_valid_o,
  output baro_pkg::item_t     item_o,
  input  wire logic           item_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  baro_pkg::item_t       mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;
  logic                  push, pop;

  // Transfers on either side of the queue.
  assign in_if.ready  = (count_q != CntW'(Depth));
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  // Storage for queued items.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{raw_temperature: in_if.raw_temperature,
                           raw_pressure: in_if.raw_pressure};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The fill count follows the transfers on both sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on a lone push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

/* rtl/core/baro_mul.sv */
`default_nettype none
module baro_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      prod_o
);

  logic [63:0] a_q, b_q, pp_q, acc_q;
  logic [2:0]  cnt_q;
  logic        done_q;
  logic [31:0] op_a, op_b;

  // One 32x32 multiplier; the product modulo 2^64 needs three partial products.
  always_comb begin
    op_a = a_q[31:0];
    op_b = b_q[31:0];
    case (cnt_q)
      3'd2: op_b = b_q[63:32];
      3'd3: op_a = a_q[63:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    pp_q <= op_a * op_b;
    case (cnt_q)
      3'd2: acc_q <= pp_q;
      3'd3, 3'd4: acc_q[63:32] <= acc_q[63:32] + pp_q[31:0];
      default: ;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 3'd4);
      if (start_i) begin
        cnt_q <= 3'd1;
      end else if (cnt_q == 3'd4) begin
        cnt_q <= '0;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

/* rtl/core/baro_div.sv */
`default_nettype none
module baro_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quo_o
);

  logic [64:0] rem_q, rem_sh, trial;
  logic [63:0] quo_q, den_q;
  logic [6:0]  cnt_q;
  logic        done_q;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q[63:0], quo_q[63]};
  assign trial  = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!trial[64]) begin
        rem_q <= trial;
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 7'd1);
      if (start_i) begin
        cnt_q <= 7'd64;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

/* rtl/core/baro_back.sv */
`default_nettype none
module baro_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  baro_pkg::item_t item_i,
  output logic            item_ready_o,
  input  baro_pkg::cal_t  cal_i,
  baro_out_if.source      out_if
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_X1   = 4'd1;
  localparam logic [3:0] S_X2   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_XA   = 4'd4;
  localparam logic [3:0] S_XB   = 4'd5;
  localparam logic [3:0] S_XC   = 4'd6;
  localparam logic [3:0] S_XD   = 4'd7;
  localparam logic [3:0] S_B4   = 4'd8;
  localparam logic [3:0] S_B7   = 4'd9;
  localparam logic [3:0] S_Q    = 4'd10;
  localparam logic [3:0] S_P1   = 4'd11;
  localparam logic [3:0] S_P2   = 4'd12;
  localparam logic [3:0] S_P3   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]      state_q;
  logic            issued_q, err_q;
  baro_pkg::item_t item_q;
  logic [63:0]     x1_q, den_q, t_q, b6_q, sq_q, acc_q, b3_q, b4_q, b7_q, p_q;

  logic            is_div, mul_start, div_start, mul_done, div_done, op_done;
  logic [63:0]     mul_a, mul_b, div_num, div_den, prod, quo;
  logic [63:0]     x1_new, den_new, x2_new, b5_new, x3_new, b4_new, p_new, p_div;
  logic [63:0]     num_t, q_num;
  logic            neg_t, small_b7;

  logic            out_valid_q, out_err_q;
  logic [15:0]     out_t_q;
  logic [31:0]     out_p_q;
  logic            out_free;

  assign item_ready_o = (state_q == S_IDLE);
  assign out_free     = !out_valid_q || out_if.ready;
  assign is_div       = (state_q == S_X2) || (state_q == S_Q);
  assign mul_start    = !issued_q && !is_div && (state_q != S_IDLE) && (state_q != S_FIN);
  assign div_start    = !issued_q && is_div;
  assign op_done      = issued_q && (is_div ? div_done : mul_done);

  // Operands of the temperature divide and the pressure divide.
  assign num_t    = baro_pkg::sx16(cal_i.mc) << 11;
  assign neg_t    = num_t[63] ^ den_q[63];
  assign small_b7 = (b7_q < baro_pkg::SmallLimit);
  assign q_num    = small_b7 ? (b7_q << 1) : b7_q;
  assign p_div    = baro_pkg::sdiv_p2(p_q, 8);

  always_comb begin
    div_num = q_num;
    div_den = b4_q;
    if (state_q == S_X2) begin
      div_num = num_t[63] ? -num_t : num_t;
      div_den = den_q[63] ? -den_q : den_q;
    end
  end

  // Multiplier operands for each step.
  always_comb begin
    mul_a = b6_q;
    mul_b = b6_q;
    unique case (state_q)
      S_X1: begin
        mul_a = {48'd0, item_q.raw_temperature} - {48'd0, cal_i.ac6};
        mul_b = {48'd0, cal_i.ac5};
      end
      S_XA: begin mul_a = baro_pkg::sx16(cal_i.b2);  mul_b = sq_q; end
      S_XB: begin mul_a = baro_pkg::sx16(cal_i.ac2); mul_b = b6_q; end
      S_XC: begin mul_a = baro_pkg::sx16(cal_i.ac3); mul_b = b6_q; end
      S_XD: begin mul_a = baro_pkg::sx16(cal_i.b1);  mul_b = sq_q; end
      S_B4: begin
        mul_a = {48'd0, cal_i.ac4};
        mul_b = acc_q + baro_pkg::PressBias;
      end
      S_B7: begin
        mul_a = {48'd0, item_q.raw_pressure} - b3_q;
        mul_b = baro_pkg::PressScale;
      end
      S_P1: begin mul_a = p_div; mul_b = p_div; end
      S_P2: begin mul_a = x1_q;  mul_b = baro_pkg::CoefSquare; end
      S_P3: begin mul_a = p_q;   mul_b = baro_pkg::CoefLinear; end
      default: ;
    endcase
  end

  // Values formed when a step completes.
  assign x1_new  = baro_pkg::sdiv_p2(prod, 15);
  assign den_new = x1_new + baro_pkg::sx16(cal_i.md);
  assign x2_new  = neg_t ? -quo : quo;
  assign b5_new  = x1_q + x2_new;
  assign x3_new  = acc_q + baro_pkg::sdiv_p2(prod, 11);
  assign b4_new  = prod >> 15;
  assign p_new   = p_q + baro_pkg::sdiv_p2(
                     acc_q + baro_pkg::sdiv_p2(prod, 16) + baro_pkg::CoefOffset, 4);

  baro_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  baro_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (item_valid_i && item_ready_o) begin
      item_q <= item_i;
    end
    if (op_done) begin
      case (state_q)
        S_X1: begin x1_q <= x1_new; den_q <= den_new; end
        S_X2: begin
          t_q  <= baro_pkg::sdiv_p2(b5_new + 64'd8, 4);
          b6_q <= b5_new - baro_pkg::TempOffset;
        end
        S_SQ: sq_q  <= baro_pkg::sdiv_p2(prod, 12);
        S_XA: acc_q <= baro_pkg::sdiv_p2(prod, 11);
        S_XB: b3_q  <= baro_pkg::sdiv_p2(
                         (baro_pkg::sx16(cal_i.ac1) << 2) + x3_new + 64'd2, 2);
        S_XC: acc_q <= baro_pkg::sdiv_p2(prod, 13);
        S_XD: acc_q <= baro_pkg::sdiv_p2(acc_q + baro_pkg::sdiv_p2(prod, 16) + 64'd2, 2);
        S_B4: b4_q  <= b4_new;
        S_B7: b7_q  <= prod;
        S_Q:  p_q   <= small_b7 ? quo : (quo << 1);
        S_P1: x1_q  <= prod;
        S_P2: acc_q <= baro_pkg::sdiv_p2(prod, 16);
        S_P3: p_q   <= p_new;
        default: ;
      endcase
    end
  end

  // Step sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      if (mul_start || div_start) begin
        issued_q <= 1'b1;
      end
      if (op_done) begin
        issued_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (item_valid_i) state_q <= S_X1;
        S_X1: if (op_done) begin
          if (den_new == '0) begin
            err_q   <= 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_X2;
          end
        end
        S_B4: if (op_done) begin
          if (b4_new == '0) begin
            err_q   <= 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_B7;
          end
        end
        S_P3: if (op_done) state_q <= S_FIN;
        S_FIN: if (out_free) begin
          err_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: if (op_done) state_q <= state_q + 4'd1;
      endcase
    end
  end

  // Output register with saturation of both results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      out_err_q <= err_q;
      if (err_q) begin
        out_t_q <= '0;
        out_p_q <= '0;
      end else begin
        if ($signed(t_q) > 64'sd32767) begin
          out_t_q <= 16'h7FFF;
        end else if ($signed(t_q) < -64'sd32768) begin
          out_t_q <= 16'h8000;
        end else begin
          out_t_q <= t_q[15:0];
        end
        if ($signed(p_q) > 64'sd2147483647) begin
          out_p_q <= 32'h7FFF_FFFF;
        end else if ($signed(p_q) < -64'sd2147483648) begin
          out_p_q <= 32'h8000_0000;
        end else begin
          out_p_q <= p_q[31:0];
        end
      end
    end
  end

  assign out_if.valid               = out_valid_q;
  assign out_if.temperature_decideg = out_t_q;
  assign out_if.pressure_pa         = out_p_q;
  assign out_if.divide_error        = out_err_q;

  // An error result carries zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.divide_error) |->
      (out_if.temperature_decideg == '0 && out_if.pressure_pa == '0))
    else $error("error result with nonzero fields");
  // A unit is only in flight during an arithmetic step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q |-> (state_q != S_IDLE && state_q != S_FIN))
    else $error("operation in flight outside an arithmetic step");
  // A new item is only taken while idle with no operation pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_o) |=> (state_q == S_X1 && !issued_q))
    else $error("item taken while engine busy");

endmodule
`default_nettype wire

/* tb/tb_if_unused.sv */
`timescale 1ns / 100ps
// Payload record for one raw reading as the stimulus tasks hand it around.
package tb_reading_pkg;
  typedef struct packed {
    logic [15:0] ut;
    logic [15:0] up;
  } reading_t;
endpackage

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [31:0] press;
    logic               err;
  } comp_t;

  // Compensation predictor and store of pending compensated readings.
  class comp_scoreboard;
    logic [47:0] offset_words, scale_words;
    logic [31:0] b_words, m_words;
    comp_t       pending[$];
    int          errors;
    int          checked;
    int          div_errors;

    function new();
      offset_words = '0;
      scale_words = '0;
      b_words = '0;
      m_words = '0;
      errors = 0;
      checked = 0;
      div_errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [47:0] data);
      case (idx)
        baro_pkg::CfgOffset: offset_words = data;
        baro_pkg::CfgScale:  scale_words = data;
        baro_pkg::CfgB:      b_words = data[31:0];
        baro_pkg::CfgM:      m_words = data[31:0];
        default: ;
      endcase
    endfunction

    function comp_t compensate(logic [15:0] ut_raw, logic [15:0] up_raw);
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
      longint x1, x2, x3, b3, b5, b6, t, p, den, sq;
      longint unsigned b4, b7, q;
      comp_t r;
      ac1 = longint'($signed(offset_words[47:32]));
      ac2 = longint'($signed(offset_words[31:16]));
      ac3 = longint'($signed(offset_words[15:0]));
      ac4 = longint'({48'd0, scale_words[47:32]});
      ac5 = longint'({48'd0, scale_words[31:16]});
      ac6 = longint'({48'd0, scale_words[15:0]});
      b1 = longint'($signed(b_words[31:16]));
      b2 = longint'($signed(b_words[15:0]));
      mc = longint'($signed(m_words[31:16]));
      md = longint'($signed(m_words[15:0]));
      ut = longint'({48'd0, ut_raw});
      up = longint'({48'd0, up_raw});
      r = '{temp: '0, press: '0, err: 1'b1};
      // Temperature path.
      x1 = ((ut - ac6) * ac5) / 32768;
      den = x1 + md;
      if (den == 0) return r;
      x2 = (mc * 2048) / den;
      b5 = x1 + x2;
      t = (b5 + 8) / 16;
      // Pressure path.
      b6 = b5 - 4000;
      sq = (b6 * b6) / 4096;
      x1 = (b2 * sq) / 2048;
      x2 = (ac2 * b6) / 2048;
      x3 = x1 + x2;
      b3 = ((ac1 * 4) + x3 + 2) / 4;
      x1 = (ac3 * b6) / 8192;
      x2 = (b1 * sq) / 65536;
      x3 = (x1 + x2 + 2) / 4;
      b4 = (longint'(unsigned'(ac4)) * longint'(unsigned'(x3 + 32768)));
      b4 = b4 / 64'd32768;
      if (b4 == 0) return r;
      b7 = (longint'(unsigned'(up)) - longint'(unsigned'(b3))) * 64'd50000;
      if (b7 < 64'h8000_0000) q = (b7 * 2) / b4;
      else q = (b7 / b4) * 2;
      p = longint'(q);
      x1 = (p / 256) * (p / 256);
      x1 = (x1 * 3038) / 65536;
      x2 = (-64'sd7357 * p) / 65536;
      p = p + (x1 + x2 + 3791) / 16;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      r.temp = t[15:0];
      r.press = p[31:0];
      r.err = 1'b0;
      return r;
    endfunction

    function void note_reading(logic [15:0] ut, logic [15:0] up);
      pending.push_back(compensate(ut, up));
    endfunction

    function void check_result(comp_t got);
      comp_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.err) div_errors++;
      if (got.temp !== exp_r.temp) begin
        $error("temperature_decideg: expected %0d, got %0d", exp_r.temp, got.temp);
        errors++;
      end
      if (got.press !== exp_r.press) begin
        $error("pressure_pa: expected %0d, got %0d", exp_r.press, got.press);
        errors++;
      end
      if (got.err !== exp_r.err) begin
        $error("divide_error: expected %0b, got %0b", exp_r.err, got.err);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;
  comp_scoreboard board;
  int unsigned idle_cycles;
  int unsigned sent;

  baro_in_if  in_ch();
  baro_out_if out_ch();

  barometer_compensation_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_ch.sink),
    .out_if    (out_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, sometimes none.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Receiver: random stalls, check every result transfer.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        board.check_result('{temp: out_ch.temperature_decideg,
                             press: out_ch.pressure_pa, err: out_ch.divide_error});
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall = gap_len();
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // One register write; the enable drops for a cycle before the next write.
  task automatic write_reg(logic [1:0] idx, logic [47:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_cal(logic [47:0] off, logic [47:0] scl, logic [31:0] bw,
                           logic [31:0] mw);
    write_reg(baro_pkg::CfgOffset, off);
    write_reg(baro_pkg::CfgScale, scl);
    write_reg(baro_pkg::CfgB, {16'd0, bw});
    write_reg(baro_pkg::CfgM, {16'd0, mw});
  endtask

  // One reading transfer; valid stays high into the next reading when no gap.
  task automatic send_reading(tb_reading_pkg::reading_t rd);
    int unsigned g;
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rd.ut;
    in_ch.raw_pressure <= rd.up;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_reading(rd.ut, rd.up);
    sent++;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic tb_reading_pkg::reading_t plausible_reading();
    tb_reading_pkg::reading_t rd;
    rd.ut = 16'($urandom_range(20000, 35000));
    rd.up = 16'($urandom_range(20000, 45000));
    return rd;
  endfunction

  // Calibration close to a real part, with random jitter.
  task automatic typical_cal();
    write_cal({16'(408 + $urandom_range(0, 400)), 16'(-72 - $urandom_range(0, 50)),
               16'(-14383 + $urandom_range(0, 2000))},
              {16'(32741 - $urandom_range(0, 2000)), 16'(32757 - $urandom_range(0, 8000)),
               16'(23153 + $urandom_range(0, 4000))},
              {16'(6190 + $urandom_range(0, 300)), 16'(4 + $urandom_range(0, 10))},
              {16'(-8711 + $urandom_range(0, 1000)), 16'(2868 + $urandom_range(0, 300))});
  endtask

  initial begin
    tb_reading_pkg::reading_t rd;
    board = new();
    sent = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = baro_pkg::CfgOffset;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: all zeros makes the temperature divisor zero.
    send_reading('{ut: 16'd0, up: 16'd0});
    send_reading('{ut: 16'hFFFF, up: 16'hFFFF});
    drain();

    // Datasheet example calibration, then field extremes.
    write_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
              {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    send_reading('{ut: 16'd27898, up: 16'd23843});
    send_reading('{ut: 16'd0, up: 16'd0});
    send_reading('{ut: 16'hFFFF, up: 16'hFFFF});
    send_reading('{ut: 16'h5555, up: 16'hAAAA});
    send_reading('{ut: 16'hAAAA, up: 16'h5555});
    drain();

    // Zero pressure divisor: ac4 zero gives b4 zero.
    write_cal({16'd408, -16'sd72, -16'sd14383}, {16'd0, 16'd32757, 16'd23153},
              {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    send_reading('{ut: 16'd27898, up: 16'd23843});
    drain();
    // Temperature divisor zero at ut == ac6 with md zero.
    write_reg(baro_pkg::CfgScale, {16'd32741, 16'd32757, 16'd23153});
    write_reg(baro_pkg::CfgM, {16'd0, -16'sd8711, 16'd0});
    send_reading('{ut: 16'd23153, up: 16'd30000});
    drain();

    // Calibration extremes drive overflow and saturation.
    write_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_0001);
    send_reading('{ut: 16'd0, up: 16'hFFFF});
    send_reading('{ut: 16'hFFFF, up: 16'd0});
    send_reading('{ut: 16'd1, up: 16'd1});
    drain();
    write_cal(48'h7FFF_8000_7FFF, 48'hFFFF_0001_0000, 32'h8000_7FFF, 32'h8000_8000);
    send_reading('{ut: 16'hFFFF, up: 16'hFFFF});
    send_reading('{ut: 16'h8000, up: 16'h7FFF});
    send_reading('{ut: 16'd0, up: 16'd0});
    drain();

    // Random phases: mostly realistic calibration, some fully random.
    for (int ph = 0; ph < 15; ph++) begin
      if (ph % 4 == 3)
        write_cal(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                  $urandom(), $urandom());
      else typical_cal();
      for (int i = 0; i < 29; i++) begin
        if ($urandom_range(0, 9) < 7) rd = plausible_reading();
        else rd = tb_reading_pkg::reading_t'($urandom());
        send_reading(rd);
      end
      drain();
    end

    $display("tb: %0d readings sent, %0d results checked, %0d with divide error.",
             sent, board.checked, board.div_errors);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
